>>> sv/b64se_pkg.sv
// Shared types, constants and the character lookup for the Base64 stream encoder.
`timescale 1ns / 1ps

package b64se_pkg;

    localparam int CharW  = 7;
    localparam int MaxOut = 4;
    localparam int CntW   = 3;

    localparam logic [CharW-1:0] PadChar    = 7'h3D;  // '='
    localparam logic [CharW-1:0] PlusChar   = 7'h2B;
    localparam logic [CharW-1:0] SlashChar  = 7'h2F;
    localparam logic [CharW-1:0] MinusChar  = 7'h2D;
    localparam logic [CharW-1:0] UnderChar  = 7'h5F;
    localparam logic [CharW-1:0] UpperBase  = 7'h41;  // 'A'

    localparam logic [1:0] Phase0 = 2'd0;
    localparam logic [1:0] Phase1 = 2'd1;
    localparam logic [1:0] Phase2 = 2'd2;

    // Characters a byte produces, with the group state it leaves behind.
    typedef struct packed {
        logic [MaxOut-1:0][CharW-1:0] chars;
        logic [CntW-1:0]              count;
        logic [1:0]                   phase_next;
        logic [3:0]                   left_next;
    } grp_res_t;

    function automatic logic [CharW-1:0] b64_char(input logic [5:0] code, input logic url);
        logic [CharW-1:0] c;
        c = {1'b0, code};
        if (code < 6'd26) begin
            b64_char = UpperBase + c;
        end else if (code < 6'd52) begin
            b64_char = c + 7'd71;          // 'a' - 26
        end else if (code < 6'd62) begin
            b64_char = c - 7'd4;           // '0' - 52
        end else if (code == 6'd62) begin
            b64_char = url ? MinusChar : PlusChar;
        end else begin
            b64_char = url ? UnderChar : SlashChar;
        end
    endfunction

endpackage

>>> sv/b64se_group.sv
// Combinational encode of one byte against the current 3-byte group state.
`timescale 1ns / 1ps

module b64se_group (
    input  logic [7:0]          data_byte,
    input  logic                last_byte,
    input  logic [1:0]          phase,
    input  logic [3:0]          left,
    input  logic                url_alphabet,
    input  logic                pad_enable,
    output b64se_pkg::grp_res_t res
);

    always_comb begin
        res = '0;
        unique case (phase)
            b64se_pkg::Phase1: begin
                res.chars[0]   = b64se_pkg::b64_char({left[1:0], data_byte[7:4]}, url_alphabet);
                res.left_next  = data_byte[3:0];
                res.phase_next = b64se_pkg::Phase2;
                res.count      = 3'd1;
                if (last_byte) begin
                    res.chars[1] = b64se_pkg::b64_char({data_byte[3:0], 2'b00}, url_alphabet);
                    res.chars[2] = b64se_pkg::PadChar;
                    res.count    = pad_enable ? 3'd3 : 3'd2;
                end
            end
            b64se_pkg::Phase2: begin
                res.chars[0]   = b64se_pkg::b64_char({left, data_byte[7:6]}, url_alphabet);
                res.chars[1]   = b64se_pkg::b64_char(data_byte[5:0], url_alphabet);
                res.left_next  = 4'd0;
                res.phase_next = b64se_pkg::Phase0;
                res.count      = 3'd2;
            end
            default: begin
                // phase 0, and the unused code 3 which behaves the same
                res.chars[0]   = b64se_pkg::b64_char(data_byte[7:2], url_alphabet);
                res.left_next  = {2'b00, data_byte[1:0]};
                res.phase_next = b64se_pkg::Phase1;
                res.count      = 3'd1;
                if (last_byte) begin
                    res.chars[1] = b64se_pkg::b64_char({data_byte[1:0], 4'b0000}, url_alphabet);
                    res.chars[2] = b64se_pkg::PadChar;
                    res.chars[3] = b64se_pkg::PadChar;
                    res.count    = pad_enable ? 3'd4 : 3'd2;
                end
            end
        endcase
        if (last_byte) begin
            res.phase_next = b64se_pkg::Phase0;
            res.left_next  = 4'd0;
        end
    end

endmodule

>>> sv/base64_stream_encoder.sv
// Top level: byte stream in, Base64 character stream out.
//
//   port group   dir  beat                      tdata (low bit up)     tlast
//   s_*          in   one message byte          data_byte[7:0]         last_byte
//   m_*          out  one Base64 char or '='    out_char[6:0], 0       last_char
//   cfg_*        in   register write            url_alphabet / pad_enable
//
// A byte is registered on accept, then encoded combinationally and moved into a
// 4-entry character buffer once that buffer is free; m_* reads from the buffer.
// Each byte yields 1 to 4 characters and m_* moves one character a cycle while
// m_tready is high; the next byte is taken in while the buffer still drains.
// s_tready stays high while the input register is empty or moves on.
// Reset (aresetn low at a clock edge) clears group state, empties the input register
// and character buffer, and sets the config registers (url_alphabet 0, pad_enable 1).
`timescale 1ns / 1ps

module base64_stream_encoder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,     // [7:0] data_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,     // [6:0] out_char, [7] zero
    output logic       m_tlast,
    input  logic       cfg_wr_en,
    input  logic       cfg_addr,
    input  logic       cfg_wdata
);

    localparam logic CfgUrl = 1'b0;
    localparam logic CfgPad = 1'b1;

    logic       url_reg;
    logic       pad_reg;
    logic [1:0] phase_reg;
    logic [3:0] left_reg;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    logic [b64se_pkg::MaxOut-1:0][b64se_pkg::CharW-1:0] chars_reg;
    logic [b64se_pkg::CntW-1:0] rem_reg;
    logic [1:0]                 idx_reg;
    logic                       res_last_reg;

    b64se_pkg::grp_res_t grp;

    logic buf_free;
    logic move;
    logic pop;

    b64se_group u_group (
        .data_byte    (in_byte_reg),
        .last_byte    (in_last_reg),
        .phase        (phase_reg),
        .left         (left_reg),
        .url_alphabet (url_reg),
        .pad_enable   (pad_reg),
        .res          (grp)
    );

    assign pop      = m_tvalid && m_tready;
    assign buf_free = (rem_reg == '0) || (rem_reg == 3'd1 && m_tready);
    assign move     = in_valid_reg && buf_free;
    assign s_tready = !in_valid_reg || move;

    assign m_tvalid = rem_reg != '0;
    assign m_tdata  = {1'b0, chars_reg[idx_reg]};
    assign m_tlast  = res_last_reg && (rem_reg == 3'd1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            url_reg      <= 1'b0;
            pad_reg      <= 1'b1;
            phase_reg    <= b64se_pkg::Phase0;
            left_reg     <= 4'd0;
            in_valid_reg <= 1'b0;
            rem_reg      <= '0;
            idx_reg      <= 2'd0;
            res_last_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    CfgUrl: url_reg <= cfg_wdata;
                    CfgPad: pad_reg <= cfg_wdata;
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (move) begin
                in_valid_reg <= 1'b0;
            end

            if (move) begin
                phase_reg    <= grp.phase_next;
                left_reg     <= grp.left_next;
                rem_reg      <= grp.count;
                idx_reg      <= 2'd0;
                res_last_reg <= in_last_reg;
            end else if (pop) begin
                rem_reg <= rem_reg - 3'd1;
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (move) begin
            chars_reg <= grp.chars;
        end
    end

endmodule
